// File: src/cdq_pkg.sv
// Package for the circular deque unit: operation codes, field widths and shared types.
`timescale 1ns / 1ps
package cdq_pkg;

    // Field widths fixed by the interface.
    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;   // func(3) + value(32) = 35 bits
    localparam int M_TDATA_W = 72;   // 1 + 32 + 32 + 1 + 1 = 67 bits

    // Operation codes; unused codes act as a peek.
    localparam logic [FUNC_W-1:0] FUNC_PEEK      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INS_REAR  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DEL_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DEL_REAR  = 3'd4;

    // Status of the deque after the last operation.
    typedef struct packed {
        logic accepted;
        logic is_empty;
        logic is_full;
    } cdq_status_t;

endpackage

// File: src/circular_deque_unit.sv
// Top level of the circular deque unit: stream ports, sequencer and result register.
`timescale 1ns / 1ps
// From input word accepted to result word valid: execute and write the slot, read front
//   and rear, load result; the load waits while the result register is still occupied.
// One item at a time: a new input word is accepted only after the last result is loaded;
//   the store's single registered read port pair is used once per item after the write has landed.
// Reset: aresetn, synchronous, active low; clears indices, sets the deque empty and
//   capacity to 16. The slot store is not cleared.
module circular_deque_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Capacity register write port.
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata,
    // Operation stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // func[2:0], value[34:3], zero pad
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // accepted[0], front_value[32:1],
                                            // rear_value[64:33], is_empty[65],
                                            // is_full[66], zero pad
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;   // take an operation and execute it
    localparam logic [1:0] ST_READ = 2'd1;   // read front and rear slots
    localparam logic [1:0] ST_LOAD = 2'd2;   // move read data into the result register

    logic [1:0]            state_reg, state_next;
    logic                  s_fire;
    logic                  load_out;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [IDX_W-1:0]      front_idx, rear_idx;
    logic [DATA_WIDTH-1:0] rd_front, rd_rear;
    cdq_status_t           status;

    logic [63:0]           rd_front_ext, rd_rear_ext;
    logic [VALUE_W-1:0]    front_word, rear_word;

    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg;

    // Accept only between items; the result register decouples the output side.
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Execute in the accept cycle: indices and empty flag update, slot written.
    cdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .exec_en   (s_fire),
        .func      (s_tdata[FUNC_W-1:0]),
        .value     (s_tdata[FUNC_W +: VALUE_W]),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .front_idx (front_idx),
        .rear_idx  (rear_idx),
        .status    (status)
    );

    // Read the next cycle, after the write has committed: no overlap to forward.
    cdq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (state_reg == ST_READ),
        .rd_addr_a (front_idx),
        .rd_addr_b (rear_idx),
        .rd_data_a (rd_front),
        .rd_data_b (rd_rear)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // Hold the read data until the result register frees up.
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign load_out = (state_reg == ST_LOAD) && (!m_valid_reg || m_tready);

    // Store words are unsigned; zero-extend or truncate to the 32-bit fields.
    assign rd_front_ext = 64'(rd_front);
    assign rd_rear_ext  = 64'(rd_rear);
    assign front_word   = status.is_empty ? '0 : rd_front_ext[VALUE_W-1:0];
    assign rear_word    = status.is_empty ? '0 : rd_rear_ext[VALUE_W-1:0];

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {5'd0, status.is_full, status.is_empty,
                           rear_word, front_word, status.accepted};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: src/cdq_store.sv
// Slot store: one write port, two registered read ports.
`timescale 1ns / 1ps
module cdq_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr_a,
    input  logic [IDX_W-1:0]      rd_addr_b,
    output logic [DATA_WIDTH-1:0] rd_data_a,
    output logic [DATA_WIDTH-1:0] rd_data_b
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// File: src/cdq_ctrl.sv
// Deque control: capacity register, front and rear indices, empty flag, operation decode.
`timescale 1ns / 1ps
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CAP_W-1:0]      cfg_wdata,
    input  logic                  exec_en,
    input  logic [FUNC_W-1:0]     func,
    input  logic [VALUE_W-1:0]    value,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output logic [DATA_WIDTH-1:0] wr_data,
    output logic [IDX_W-1:0]      front_idx,
    output logic [IDX_W-1:0]      rear_idx,
    output cdq_status_t           status
);

    localparam int CAPX_W = IDX_W + 1;

    logic [CAP_W-1:0]  cap_reg;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [IDX_W-1:0]  rear_reg, rear_next;
    logic              empty_reg, empty_next;
    logic              ok_reg, ok_next;

    logic [CAPX_W-1:0] cap_eff;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  front_inc, front_dec, rear_inc, rear_dec;
    logic              full_now;
    logic [63:0]       value_ext;

    // Clamp capacity into 1..DEPTH.
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CAPX_W'(1);
        end else if (32'(cap_reg) > 32'(DEPTH)) begin
            cap_eff = CAPX_W'(DEPTH);
        end else begin
            cap_eff = CAPX_W'(cap_reg);
        end
    end

    assign last_idx  = IDX_W'(cap_eff - CAPX_W'(1));
    assign front_inc = (front_reg == last_idx) ? '0 : front_reg + IDX_W'(1);
    assign front_dec = (front_reg == '0) ? last_idx : front_reg - IDX_W'(1);
    assign rear_inc  = (rear_reg == last_idx) ? '0 : rear_reg + IDX_W'(1);
    assign rear_dec  = (rear_reg == '0) ? last_idx : rear_reg - IDX_W'(1);
    assign full_now  = !empty_reg && (rear_inc == front_reg);

    assign value_ext = 64'(value);
    assign wr_data   = value_ext[DATA_WIDTH-1:0];

    always_comb begin
        front_next = front_reg;
        rear_next  = rear_reg;
        empty_next = empty_reg;
        ok_next    = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = '0;
        case (func)
            FUNC_INS_FRONT: begin
                if (full_now) begin
                    ok_next = 1'b0;
                end else if (empty_reg) begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                    wr_en      = exec_en;
                end else begin
                    front_next = front_dec;
                    wr_addr    = front_dec;
                    wr_en      = exec_en;
                end
            end
            FUNC_INS_REAR: begin
                if (full_now) begin
                    ok_next = 1'b0;
                end else if (empty_reg) begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                    wr_en      = exec_en;
                end else begin
                    rear_next = rear_inc;
                    wr_addr   = rear_inc;
                    wr_en     = exec_en;
                end
            end
            FUNC_DEL_FRONT: begin
                if (empty_reg) begin
                    ok_next = 1'b0;
                end else if (front_reg == rear_reg) begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b1;
                end else begin
                    front_next = front_inc;
                end
            end
            FUNC_DEL_REAR: begin
                if (empty_reg) begin
                    ok_next = 1'b0;
                end else if (front_reg == rear_reg) begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b1;
                end else begin
                    rear_next = rear_dec;
                end
            end
            default: begin
                ok_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_RESET;
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
            ok_reg    <= 1'b1;
        end else if (cfg_we) begin
            // New capacity: drop all entries, keep the store.
            cap_reg   <= cfg_wdata;
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
        end else if (exec_en) begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
            ok_reg    <= ok_next;
        end
    end

    assign front_idx       = front_reg;
    assign rear_idx        = rear_reg;
    assign status.accepted = ok_reg;
    assign status.is_empty = empty_reg;
    assign status.is_full  = full_now;

endmodule
